// File: src/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    // operand and result width
    localparam int DATA_WIDTH = 31;
    // signed Bezout coefficients: |t| stays within the modulus, plus sign and headroom
    localparam int T_WIDTH    = DATA_WIDTH + 2;
    // shift count of the aligned divisor, at most DATA_WIDTH-1
    localparam int K_WIDTH    = $clog2(DATA_WIDTH);

    // config port: 32-bit registers at byte address 4*i
    localparam int ADDR_WIDTH = 3;
    localparam int IDX_WIDTH  = ADDR_WIDTH - 2;
    localparam int PDATA_WIDTH = 32;

    localparam logic [IDX_WIDTH-1:0] REG_MODULUS = IDX_WIDTH'(0);

    localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(1000000007);

    typedef struct packed {
        logic                  valid;
        logic [DATA_WIDTH-1:0] inverse;
        logic                  no_inverse;
    } t_result;

endpackage

`default_nettype wire

// File: src/mie_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mie_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_go,
    input  wire logic [mie_pkg::DATA_WIDTH-1:0] i_value,
    input  wire logic [mie_pkg::DATA_WIDTH-1:0] i_modulus,
    output logic                                o_busy,
    output mie_pkg::t_result                    o_res
);
    import mie_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_ALIGN = 5'b00100,
        S_SUB   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [DATA_WIDTH-1:0]     r_r0, n_r0, r_r1, n_r1, r_sr, n_sr, r_m, n_m;
    logic signed [T_WIDTH-1:0] r_t0, n_t0, r_t1, n_t1, r_st, n_st;
    logic [K_WIDTH-1:0]        r_k, n_k;
    t_result                   r_res, n_res;

    logic [DATA_WIDTH:0]       w_opd;
    logic [DATA_WIDTH+1:0]     w_diff;
    logic                      w_ge;
    logic signed [T_WIDTH-1:0] w_tdiff;
    logic signed [T_WIDTH-1:0] w_tfix;
    logic [DATA_WIDTH-1:0]     w_rem;

    // shared compare/subtract: r0 against 2*sr while aligning, against sr otherwise
    assign w_opd   = (r_state == S_ALIGN) ? {r_sr, 1'b0} : {1'b0, r_sr};
    assign w_diff  = {2'b00, r_r0} - {1'b0, w_opd};
    assign w_ge    = ~w_diff[DATA_WIDTH+1];
    assign w_tdiff = r_t0 - r_st;
    assign w_tfix  = r_t0 + $signed({2'b00, r_m});
    assign w_rem   = w_ge ? w_diff[DATA_WIDTH-1:0] : r_r0;

    always_comb begin
        n_state = r_state;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_sr    = r_sr;
        n_m     = r_m;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_st    = r_st;
        n_k     = r_k;
        n_res   = r_res;
        n_res.valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_r0    = i_modulus;
                    n_r1    = i_value;
                    n_m     = i_modulus;
                    n_t0    = '0;
                    n_t1    = T_WIDTH'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_r1 == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_sr    = r_r1;
                    n_st    = r_t1;
                    n_k     = '0;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // grow divisor while it still fits twice under the remainder
                if (w_ge) begin
                    n_sr = {r_sr[DATA_WIDTH-2:0], 1'b0};
                    n_st = r_st <<< 1;
                    n_k  = r_k + K_WIDTH'(1);
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (r_k == '0) begin
                    // last quotient bit: rotate the remainder sequence
                    n_r0    = r_r1;
                    n_r1    = w_rem;
                    n_t0    = r_t1;
                    n_t1    = w_ge ? w_tdiff : r_t0;
                    n_state = S_CHECK;
                end else begin
                    if (w_ge) begin
                        n_r0 = w_diff[DATA_WIDTH-1:0];
                        n_t0 = w_tdiff;
                    end
                    n_sr = {1'b0, r_sr[DATA_WIDTH-1:1]};
                    n_st = r_st >>> 1;
                    n_k  = r_k - K_WIDTH'(1);
                end
            end
            S_FIN: begin
                n_res.valid = 1'b1;
                if (r_m == '0) begin
                    n_res.inverse    = '0;
                    n_res.no_inverse = 1'b1;
                end else if (r_m == DATA_WIDTH'(1)) begin
                    n_res.inverse    = '0;
                    n_res.no_inverse = 1'b0;
                end else if (r_r0 != DATA_WIDTH'(1)) begin
                    n_res.inverse    = '0;
                    n_res.no_inverse = 1'b1;
                end else begin
                    n_res.inverse    = r_t0[T_WIDTH-1] ? w_tfix[DATA_WIDTH-1:0]
                                                       : r_t0[DATA_WIDTH-1:0];
                    n_res.no_inverse = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r0 <= n_r0;
        r_r1 <= n_r1;
        r_sr <= n_sr;
        r_m  <= n_m;
        r_t0 <= n_t0;
        r_t1 <= n_t1;
        r_st <= n_st;
        r_k  <= n_k;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: src/modular_inverse_ext_euclid.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                                  handshake
// -------   ---------  -------------------------------------  ---------------------------
// command   in         i_value                                start high while busy low
// result    out        o_inverse, o_no_inverse                o_valid, one cycle, no stall
// config    in/out     psel penable pwrite paddr pwdata       APB, pready tied high
//                      prdata pready
//
// Each Euclid step first aligns the divisor, then develops the quotient, as the shared
// compare/subtract does one alignment shift or quotient bit a cycle. busy stays high
// from the accepting edge until the strobe; o_valid shows in the first idle cycle, so
// the next start may coincide with it. Synchronous active-low reset idles the
// sequencer and reloads modulus 1000000007; the receiver cannot stall.

module modular_inverse_ext_euclid (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [mie_pkg::DATA_WIDTH-1:0]   i_value,
    // result
    output logic                                  o_valid,
    output logic [mie_pkg::DATA_WIDTH-1:0]        o_inverse,
    output logic                                  o_no_inverse,
    // config
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mie_pkg::ADDR_WIDTH-1:0]   paddr,
    input  wire logic [mie_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [mie_pkg::PDATA_WIDTH-1:0]       prdata,
    output logic                                  pready
);
    import mie_pkg::*;

    logic [DATA_WIDTH-1:0] r_modulus;
    logic [IDX_WIDTH-1:0]  w_idx;
    logic                  w_wr;
    logic                  w_go;
    logic                  w_busy;
    t_result               w_res;

    // register index is the word address; low byte bits ignored
    assign w_idx  = paddr[ADDR_WIDTH-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (w_wr && (w_idx == REG_MODULUS)) begin
            r_modulus <= pwdata[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MODULUS: prdata = PDATA_WIDTH'(r_modulus);
            default:     prdata = '0;
        endcase
    end

    assign w_go = start & ~w_busy;

    mie_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_value   (i_value),
        .i_modulus (r_modulus),
        .o_busy    (w_busy),
        .o_res     (w_res)
    );

    assign busy         = w_busy;
    assign o_valid      = w_res.valid;
    assign o_inverse    = w_res.inverse;
    assign o_no_inverse = w_res.no_inverse;

    // an accepted word always keeps the unit busy on the next cycle
    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    // result strobe lands only once the unit has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // flagged results carry zero
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_inverse) |-> (o_inverse == '0))
        else $error("non-zero inverse with no_inverse set");

endmodule

`default_nettype wire

// File: tb/tb_modular_inverse_ext_euclid.sv
`timescale 1ns / 1ps

// Testbench for the extended-Euclid modular inverse.
// Values go in over the start/busy command handshake; each accepted word gives
// exactly one result strobe on o_valid, which cannot be held off. A scoreboard
// object keeps its own copy of the modulus, works out the expected inverse for
// every accepted value and checks the results in order.
module tb_modular_inverse_ext_euclid;

    import mie_pkg::*;

    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  DRAIN_CYCLES = 300;   // longer than the slowest Euclid run
    localparam int  PHASE_WORDS = 88;     // eight random phases, about 700 words
    localparam int  MAX_GAP     = 11;
    localparam logic [DATA_WIDTH-1:0] VALUE_MASK = '1;

    // expected result for one word
    typedef struct packed {
        logic [DATA_WIDTH-1:0] inverse;
        logic                  no_inverse;
    } t_inverse_word;

    // -------------------------------------------------------------------------
    // Scoreboard: its own modulus copy, the inverse predictor and the queue of
    // inverses still owed by the block.
    // -------------------------------------------------------------------------
    class inverse_scoreboard;
        logic [DATA_WIDTH-1:0] modulus;
        t_inverse_word         owed_inverses[$];
        int                    checked;
        int                    mismatches;
        int                    non_units;

        function new();
            modulus    = MODULUS_RESET;
            checked    = 0;
            mismatches = 0;
            non_units  = 0;
        endfunction

        function void set_modulus(logic [DATA_WIDTH-1:0] m);
            modulus = m;
        endfunction

        function int owed();
            return owed_inverses.size();
        endfunction

        // Euclid with the value's Bezout coefficient carried along
        function t_inverse_word predict_inverse(logic [DATA_WIDTH-1:0] v);
            t_inverse_word w;
            longint m, r0, r1, rn, t0, t1, tn, q;
            w.inverse    = '0;
            w.no_inverse = 1'b0;
            m = longint'(modulus);
            if (m == 0) begin
                w.no_inverse = 1'b1;
                return w;
            end
            if (m == 1)
                return w;
            r0 = m;
            r1 = longint'(v) % m;
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q  = r0 / r1;
                rn = r0 - q * r1;
                tn = t0 - q * t1;
                r0 = r1;
                r1 = rn;
                t0 = t1;
                t1 = tn;
            end
            if (r0 != 1) begin
                w.no_inverse = 1'b1;
                return w;
            end
            // negative coefficient is pulled back into [0, m-1]
            if (t0 < 0)
                t0 = t0 + m;
            w.inverse = DATA_WIDTH'(t0);
            return w;
        endfunction

        function void note_value(logic [DATA_WIDTH-1:0] v);
            owed_inverses.push_back(predict_inverse(v));
        endfunction

        function void note_failure(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_result(logic [DATA_WIDTH-1:0] inv, logic none);
            t_inverse_word exp_w;
            if (owed_inverses.size() == 0) begin
                note_failure($sformatf("unexpected result inverse=%0d no_inverse=%0b",
                                       inv, none));
                return;
            end
            exp_w = owed_inverses.pop_front();
            checked++;
            if (exp_w.no_inverse)
                non_units++;
            if (inv !== exp_w.inverse || none !== exp_w.no_inverse)
                note_failure($sformatf(
                    "result %0d: expected inverse=%0d no_inverse=%0b, got %0d/%0b",
                    checked, exp_w.inverse, exp_w.no_inverse, inv, none));
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // DUT signals; every input is known from time zero
    // -------------------------------------------------------------------------
    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start   = 1'b0;
    logic [DATA_WIDTH-1:0]   i_value = '0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [ADDR_WIDTH-1:0]   paddr   = '0;
    logic [PDATA_WIDTH-1:0]  pwdata  = '0;
    logic                    busy;
    logic                    o_valid;
    logic [DATA_WIDTH-1:0]   o_inverse;
    logic                    o_no_inverse;
    logic [PDATA_WIDTH-1:0]  prdata;
    logic                    pready;

    inverse_scoreboard sb = new();

    int  cycle_count = 0;
    int  words_sent  = 0;
    int  modulus_writes = 0;
    bit  burst_mode  = 1'b0;   // stretch of back-to-back words, no gaps

    modular_inverse_ext_euclid uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_inverse   (o_inverse),
        .o_no_inverse(o_no_inverse),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, sb.owed());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result strobe: sampled at the edge that closes its single cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_inverse, o_no_inverse);
    end

    // -------------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------------

    // Offer one word. start is left high on return so that a zero gap keeps it
    // high into the next word without a low/high pair in one step.
    task automatic send_value(input logic [DATA_WIDTH-1:0] v);
        int gap;
        if ($urandom_range(0, 15) == 0)
            burst_mode = ~burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        // accepted at the edge where start is high and busy is low
        do
            @(posedge i_clk);
        while (busy);
        sb.note_value(v);
        words_sent++;
    endtask

    // Wait until every owed result has come back; one result per word, so the
    // block is idle once the queue is empty.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.owed() != 0)
            @(posedge i_clk);
    endtask

    // APB write of the modulus, then a read back of the same register.
    task automatic write_modulus(input logic [DATA_WIDTH-1:0] m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODULUS, 2'b00};
        pwdata  <= PDATA_WIDTH'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        sb.set_modulus(m);
        modulus_writes++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata[DATA_WIDTH-1:0] !== m)
            sb.note_failure($sformatf("modulus read back %0d, expected %0d",
                                      prdata[DATA_WIDTH-1:0], m));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random value for the current modulus m. factor divides m, so multiples
    // of it have no inverse unless factor is 1.
    function automatic logic [DATA_WIDTH-1:0] draw_value(
        input logic [DATA_WIDTH-1:0] m, input logic [DATA_WIDTH-1:0] factor);
        longint v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = longint'($urandom) & longint'(VALUE_MASK);
            3:       v = $urandom_range(0, 1000);
            4:       v = longint'($urandom) % longint'(m);    // already reduced
            5, 6:    v = longint'(factor) *
                         longint'($urandom_range(0, int'(VALUE_MASK / factor)));
            7:       v = longint'(m) + $urandom_range(0, 2) - 1; // around m
            8:       v = longint'(m) * $urandom_range(2, 3) + $urandom_range(0, 1);
            default: v = longint'($urandom) & longint'(VALUE_MASK);
        endcase
        return DATA_WIDTH'(v);
    endfunction

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] phase_modulus [8];
    logic [DATA_WIDTH-1:0] phase_factor  [8];

    initial begin
        int a, b;

        // sync reset, then release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset modulus 1000000007 (prime) ---
        send_value('0);                        // zero: no inverse
        send_value(DATA_WIDTH'(1));
        send_value(DATA_WIDTH'(2));
        send_value(VALUE_MASK);                // all ones, reduced first
        send_value(MODULUS_RESET - 1'b1);      // self-inverse
        send_value(MODULUS_RESET);             // multiple of modulus
        send_value(MODULUS_RESET + 1'b1);
        send_value(DATA_WIDTH'(2 * 64'(MODULUS_RESET)));
        send_value(DATA_WIDTH'(31'h2AAA_AAAA));
        send_value(DATA_WIDTH'(31'h5555_5555));
        wait_drained();

        // consecutive Fibonacci numbers: the longest Euclid chain at this width
        write_modulus(DATA_WIDTH'(1836311903));
        send_value(DATA_WIDTH'(1134903170));
        send_value(DATA_WIDTH'(1836311902));
        wait_drained();

        // modulus of one: everything maps to 0 with no flag
        write_modulus(DATA_WIDTH'(1));
        send_value(VALUE_MASK);
        send_value('0);
        wait_drained();

        // largest modulus
        write_modulus(VALUE_MASK);
        send_value(VALUE_MASK);
        send_value(VALUE_MASK - 1'b1);
        send_value(DATA_WIDTH'(2));
        send_value(DATA_WIDTH'(31'h4000_0000));
        wait_drained();

        // --- random phases over a spread of moduli ---
        a = $urandom_range(3, 46340);
        b = $urandom_range(3, 46340);
        phase_modulus = '{DATA_WIDTH'(1), DATA_WIDTH'(2), DATA_WIDTH'(360),
                          VALUE_MASK, DATA_WIDTH'(1836311903),
                          DATA_WIDTH'(1000000006), DATA_WIDTH'(65521),
                          DATA_WIDTH'(a * b)};
        phase_factor  = '{DATA_WIDTH'(1), DATA_WIDTH'(2), DATA_WIDTH'(6),
                          VALUE_MASK, DATA_WIDTH'(139), DATA_WIDTH'(2),
                          DATA_WIDTH'(65521), DATA_WIDTH'(a)};
        // shuffle the order so the moduli meet different block histories
        for (int i = 7; i > 0; i--) begin
            int j;
            logic [DATA_WIDTH-1:0] tm, tf;
            j  = $urandom_range(0, i);
            tm = phase_modulus[i]; phase_modulus[i] = phase_modulus[j];
            phase_modulus[j] = tm;
            tf = phase_factor[i];  phase_factor[i]  = phase_factor[j];
            phase_factor[j]  = tf;
        end

        for (int p = 0; p < 8; p++) begin
            write_modulus(phase_modulus[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_value(draw_value(phase_modulus[p], phase_factor[p]));
            wait_drained();
        end

        // back to the reset value for a final stretch
        write_modulus(MODULUS_RESET);
        for (int n = 0; n < 40; n++)
            send_value(draw_value(MODULUS_RESET, MODULUS_RESET));
        wait_drained();

        // anything still in flight shows up as an unexpected strobe here
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.owed() != 0)
            sb.note_failure($sformatf("%0d results never arrived", sb.owed()));

        $display("run covered %0d words over %0d modulus writes, %0d results checked",
                 words_sent, modulus_writes, sb.checked);
        $display("%0d results without an inverse, %0d mismatches, %0d cycles",
                 sb.non_units, sb.mismatches, cycle_count);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
